>>> rtl/core/gb2_pkg.sv
package gb2_pkg;

  localparam int MAP_AW      = 12;
  localparam int GLYPH_AW    = 8;
  localparam int BYTE_AW     = 12;
  localparam int TILE_SHIFT  = 4;
  localparam int FRAME_AW    = 20;
  localparam int MAX_COLS    = 8;
  localparam int MAX_ROWS    = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic [8:0] NO_GLYPH = 9'h100;

  localparam logic [2:0] ACT_MAP   = 3'd0;
  localparam logic [2:0] ACT_BYTE  = 3'd1;
  localparam logic [2:0] ACT_SPACE = 3'd2;
  localparam logic [2:0] ACT_WIDTH = 3'd3;
  localparam logic [2:0] ACT_DRAW  = 3'd4;

  localparam logic [2:0] CFG_TILE_COLUMNS = 3'd0;
  localparam logic [2:0] CFG_TILE_ROWS    = 3'd1;
  localparam logic [2:0] CFG_LINE_PITCH   = 3'd2;
  localparam logic [2:0] CFG_REPLACEMENT  = 3'd3;
  localparam logic [2:0] CFG_PALETTE_0    = 3'd4;
  localparam logic [2:0] CFG_PALETTE_1    = 3'd5;
  localparam logic [2:0] CFG_PALETTE_2    = 3'd6;
  localparam logic [2:0] CFG_PALETTE_3    = 3'd7;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_SPACE,
    CMD_WIDTH,
    CMD_DRAW
  } cmd_kind_t;

  // For a draw, value carries the glyph number.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [11:0] index;
    logic [7:0]  value;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  tile_columns;
    logic [3:0]  tile_rows;
    logic [12:0] line_pitch;
    logic [15:0] palette_0;
    logic [15:0] palette_1;
    logic [15:0] palette_2;
    logic [15:0] palette_3;
  } draw_cfg_t;

endpackage

>>> rtl/core/gb2_front.sv
module gb2_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [63:0]      s_axis_tdata,
  input  logic [2:0]       s_axis_tuser,
  input  logic [11:0]      replacement_code,
  output logic             q_push,
  output gb2_pkg::cmd_t    q_data,
  input  logic             q_ready
);

  localparam logic [2:0] F_CLEAR = 3'd0;
  localparam logic [2:0] F_IDLE  = 3'd1;
  localparam logic [2:0] F_LOOK1 = 3'd2;
  localparam logic [2:0] F_LOOK2 = 3'd3;
  localparam logic [2:0] F_PUSH  = 3'd4;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [gb2_pkg::MAP_AW-1:0] clear_addr;
  logic [8:0]  code_map [2**gb2_pkg::MAP_AW];
  logic [8:0]  map_rd;
  logic [gb2_pkg::MAP_AW-1:0] map_raddr;
  logic [gb2_pkg::MAP_AW-1:0] map_waddr;
  logic [8:0]  map_wdata;
  logic        map_we;
  logic [7:0]  glyph;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic        accept;
  logic [2:0]  action;
  logic [11:0] table_index;
  logic [8:0]  table_value;
  logic [11:0] codepoint;
  logic        is_write;

  assign action      = s_axis_tuser;
  assign table_index = s_axis_tdata[11:0];
  assign table_value = s_axis_tdata[20:12];
  assign codepoint   = s_axis_tdata[32:21];

  assign s_axis_tready = (state == F_IDLE) && q_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_write      = (action == gb2_pkg::ACT_BYTE) || (action == gb2_pkg::ACT_SPACE)
                         || (action == gb2_pkg::ACT_WIDTH);

  always_comb begin
    map_we    = 1'b0;
    map_waddr = table_index;
    map_wdata = table_value;
    if (state == F_CLEAR) begin
      map_we    = 1'b1;
      map_waddr = clear_addr;
      map_wdata = gb2_pkg::NO_GLYPH;
    end else if (accept && action == gb2_pkg::ACT_MAP) begin
      map_we = 1'b1;
    end
    map_raddr = (state == F_LOOK1) ? replacement_code : codepoint;
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      code_map[map_waddr] <= map_wdata;
    end
    map_rd <= code_map[map_raddr];
  end

  always_comb begin
    state_next = state;
    q_push     = 1'b0;
    q_data.kind  = gb2_pkg::CMD_DRAW;
    q_data.index = table_index;
    q_data.value = glyph;
    q_data.pos_x = pos_x;
    q_data.pos_y = pos_y;
    unique case (state)
      F_CLEAR: begin
        if (&clear_addr) begin
          state_next = F_IDLE;
        end
      end
      F_IDLE: begin
        if (accept) begin
          if (is_write) begin
            q_push       = 1'b1;
            q_data.value = table_value[7:0];
            priority if (action == gb2_pkg::ACT_BYTE) begin
              q_data.kind = gb2_pkg::CMD_BYTE;
            end else if (action == gb2_pkg::ACT_SPACE) begin
              q_data.kind = gb2_pkg::CMD_SPACE;
            end else begin
              q_data.kind = gb2_pkg::CMD_WIDTH;
            end
          end else if (action == gb2_pkg::ACT_DRAW) begin
            state_next = F_LOOK1;
          end
        end
      end
      F_LOOK1: begin
        state_next = map_rd[8] ? F_LOOK2 : F_PUSH;
      end
      F_LOOK2: begin
        state_next = map_rd[8] ? F_IDLE : F_PUSH;
      end
      F_PUSH: begin
        if (q_ready) begin
          q_push     = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (state == F_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_x <= s_axis_tdata[44:33];
      pos_y <= s_axis_tdata[56:45];
    end
    if (state == F_LOOK1 || state == F_LOOK2) begin
      glyph <= map_rd[7:0];
    end
  end

endmodule

>>> rtl/core/gb2_queue.sv
module gb2_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gb2_pkg::cmd_t push_data,
  output logic          push_ready,
  input  logic          pop,
  output gb2_pkg::cmd_t pop_data,
  output logic          pop_valid
);

  gb2_pkg::cmd_t entries [gb2_pkg::QUEUE_DEPTH];
  logic [gb2_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [gb2_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [gb2_pkg::QUEUE_AW:0]   count;
  logic do_push;
  logic do_pop;

  assign push_ready = (count != (gb2_pkg::QUEUE_AW+1)'(gb2_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/gb2_back.sv
module gb2_back (
  input  logic               clk,
  input  logic               rst,
  input  gb2_pkg::draw_cfg_t cfg,
  input  logic               q_valid,
  input  gb2_pkg::cmd_t      q_data,
  output logic               q_pop,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [39:0]        m_axis_tdata,
  output logic               m_axis_tuser,
  output logic               m_axis_tlast
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_LOOK = 2'd1;
  localparam logic [1:0] B_RUN  = 2'd2;

  logic [1:0]  state;
  logic [7:0]  glyph_bytes [2**gb2_pkg::BYTE_AW];
  logic [3:0]  left_space  [2**gb2_pkg::GLYPH_AW];
  logic [3:0]  glyph_width [2**gb2_pkg::GLYPH_AW];

  logic [7:0]  glyph;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [3:0]  lsp;
  logic [3:0]  wid;
  logic [3:0]  ncols;
  logic [3:0]  rows;
  logic [2:0]  col;
  logic [2:0]  row;
  logic [gb2_pkg::FRAME_AW-1:0] row_base;
  logic [6:0]  row_pix;

  logic        stall;
  logic        a_fire;
  logic        a_space;
  logic [2:0]  a_n;
  logic [6:0]  a_pix;
  logic [gb2_pkg::BYTE_AW-1:0] a_byte_addr;
  logic        a_row_end;
  logic        a_last;
  logic [4:0]  span;
  logic [3:0]  ncols_calc;
  logic [3:0]  rows_calc;
  logic [24:0] base_prod;

  logic        b_valid;
  logic        b_space;
  logic [1:0]  b_shift;
  logic [gb2_pkg::FRAME_AW-1:0] b_addr;
  logic        b_last;
  logic [7:0]  byte_rd;
  logic [1:0]  sel;
  logic [15:0] color;

  logic [gb2_pkg::FRAME_AW-1:0] out_addr;
  logic [15:0] out_color;
  logic        out_we;
  logic        out_last;

  assign q_pop = (state == B_IDLE) && q_valid;
  assign stall = m_axis_tvalid && !m_axis_tready;

  always_ff @(posedge clk) begin
    if (q_pop && q_data.kind == gb2_pkg::CMD_BYTE) begin
      glyph_bytes[q_data.index] <= q_data.value;
    end
    if (!stall) begin
      byte_rd <= glyph_bytes[a_byte_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.kind == gb2_pkg::CMD_SPACE) begin
      left_space[q_data.index[gb2_pkg::GLYPH_AW-1:0]] <= q_data.value[3:0];
    end
    if (q_pop && q_data.kind == gb2_pkg::CMD_DRAW) begin
      lsp <= left_space[q_data.value];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.kind == gb2_pkg::CMD_WIDTH) begin
      glyph_width[q_data.index[gb2_pkg::GLYPH_AW-1:0]] <= q_data.value[3:0];
    end
    if (q_pop && q_data.kind == gb2_pkg::CMD_DRAW) begin
      wid <= glyph_width[q_data.value];
    end
  end

  always_comb begin
    span       = {1'b0, lsp} + {1'b0, wid};
    ncols_calc = (span > 5'(gb2_pkg::MAX_COLS)) ? 4'(gb2_pkg::MAX_COLS) : span[3:0];
    rows_calc  = (cfg.tile_rows > 4'(gb2_pkg::MAX_ROWS)) ? 4'(gb2_pkg::MAX_ROWS)
                                                           : cfg.tile_rows;
    base_prod  = pos_y * cfg.line_pitch;
  end

  always_comb begin
    a_fire      = (state == B_RUN) && !stall;
    a_space     = {1'b0, col} < lsp;
    a_n         = col - lsp[2:0];
    a_pix       = row_pix + {4'b0, a_n};
    a_byte_addr = {glyph, {gb2_pkg::TILE_SHIFT{1'b0}}} + {7'b0, a_pix[6:2]};
    a_row_end   = ({1'b0, col} == (ncols - 4'd1));
    a_last      = a_row_end && ({1'b0, row} == (rows - 4'd1));
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.kind == gb2_pkg::CMD_DRAW) begin
      glyph <= q_data.value;
      pos_x <= q_data.pos_x;
      pos_y <= q_data.pos_y;
    end
    if (state == B_LOOK) begin
      ncols    <= ncols_calc;
      rows     <= rows_calc;
      col      <= '0;
      row      <= '0;
      row_pix  <= '0;
      row_base <= base_prod[gb2_pkg::FRAME_AW-1:0] + {8'b0, pos_x};
    end else if (a_fire) begin
      if (a_row_end) begin
        col      <= '0;
        row      <= row + 1'b1;
        row_pix  <= row_pix + {3'b0, cfg.tile_columns};
        row_base <= row_base + {7'b0, cfg.line_pitch};
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (q_pop && q_data.kind == gb2_pkg::CMD_DRAW) begin
            state <= B_LOOK;
          end
        end
        B_LOOK: begin
          state <= (ncols_calc == '0 || rows_calc == '0) ? B_IDLE : B_RUN;
        end
        B_RUN: begin
          if (a_fire && a_last) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      b_space <= a_space;
      b_shift <= a_pix[1:0];
      b_addr  <= row_base + {17'b0, col};
      b_last  <= a_last;
    end
  end

  always_comb begin
    if (b_space) begin
      sel = 2'd0;
    end else begin
      unique case (b_shift)
        2'd0: sel = byte_rd[7:6];
        2'd1: sel = byte_rd[5:4];
        2'd2: sel = byte_rd[3:2];
        2'd3: sel = byte_rd[1:0];
      endcase
    end
    unique case (sel)
      2'd0: color = cfg.palette_0;
      2'd1: color = cfg.palette_1;
      2'd2: color = cfg.palette_2;
      2'd3: color = cfg.palette_3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      out_addr  <= b_addr;
      out_color <= color;
      out_we    <= (color != '0);
      out_last  <= b_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (!stall) begin
      b_valid       <= a_fire;
      m_axis_tvalid <= b_valid;
    end
  end

  assign m_axis_tdata = {4'b0, out_color, out_addr};
  assign m_axis_tuser = out_we;
  assign m_axis_tlast = out_last;

endmodule

>>> rtl/core/glyph_blit_2bpp.sv
// Channel   Direction  Transfer carries
// s_axis    in         tuser: action; tdata: table_index, table_value, codepoint, pos_x, pos_y
// m_axis    out        tuser: write_enable; tdata: pixel_address, pixel_color; tlast: last_pixel
// cfg       in         cfg_write, cfg_index, cfg_data; one register per write, no read-back
//
// After reset the code map is cleared, all 4096 entries, with s_axis_tready low. A table write
// is pushed to the queue in the cycle it is accepted. A draw looks up its codepoint, and the
// replacement code if that has no glyph; the back then draws up to 64 pixels, running a
// setup state and then one pixel per cycle unless m_axis stalls, which holds the pipeline.
// The command queue holds four entries; the front keeps accepting until the queue fills.
module glyph_blit_2bpp (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // table_index, table_value, codepoint, pos_x, pos_y
  input  logic [2:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // pixel_address, pixel_color
  output logic        m_axis_tuser,   // write_enable
  output logic        m_axis_tlast,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  gb2_pkg::draw_cfg_t cfg;
  logic [11:0]        replacement_code;
  logic               q_push;
  logic               q_push_ready;
  gb2_pkg::cmd_t      q_push_data;
  logic               q_pop;
  logic               q_pop_valid;
  gb2_pkg::cmd_t      q_pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_columns <= 4'd8;
      cfg.tile_rows    <= 4'd8;
      cfg.line_pitch   <= 13'd256;
      replacement_code <= 12'd63;
      cfg.palette_0    <= 16'd0;
      cfg.palette_1    <= 16'd0;
      cfg.palette_2    <= 16'd0;
      cfg.palette_3    <= 16'hFFFF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gb2_pkg::CFG_TILE_COLUMNS: cfg.tile_columns <= cfg_data[3:0];
        gb2_pkg::CFG_TILE_ROWS:    cfg.tile_rows    <= cfg_data[3:0];
        gb2_pkg::CFG_LINE_PITCH:   cfg.line_pitch   <= cfg_data[12:0];
        gb2_pkg::CFG_REPLACEMENT:  replacement_code <= cfg_data[11:0];
        gb2_pkg::CFG_PALETTE_0:    cfg.palette_0    <= cfg_data;
        gb2_pkg::CFG_PALETTE_1:    cfg.palette_1    <= cfg_data;
        gb2_pkg::CFG_PALETTE_2:    cfg.palette_2    <= cfg_data;
        gb2_pkg::CFG_PALETTE_3:    cfg.palette_3    <= cfg_data;
      endcase
    end
  end

  gb2_front u_front (
    .clk              (clk),
    .rst              (rst),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .replacement_code (replacement_code),
    .q_push           (q_push),
    .q_data           (q_push_data),
    .q_ready          (q_push_ready)
  );

  gb2_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_data   (q_pop_data),
    .pop_valid  (q_pop_valid)
  );

  gb2_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_pop_valid),
    .q_data        (q_pop_data),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
